>>> rtl/dpbp_pkg.sv
// Shared types and constants for the depth pixel back-projection block.
// Used by dpbp_divider and depth_pixel_back_projection; depends on nothing.
package dpbp_pkg;

  // Valid raw depth window, inclusive.
  localparam logic [15:0] DepthMin = 16'd300;
  localparam logic [15:0] DepthMax = 16'd9000;

  // Divider geometry: numerator width, divisor width, quotient bits.
  localparam int unsigned NumW = 48;
  localparam int unsigned DenW = 32;
  localparam int unsigned QuoW = 32;
  localparam int unsigned DivLat = QuoW + 1;

  // Reset values of the configuration registers.
  localparam logic [15:0] ScaleRst   = 16'd1000;
  localparam logic [15:0] CenterXRst = 16'd5120;
  localparam logic [15:0] CenterYRst = 16'd3840;
  localparam logic [15:0] FocalXRst  = 16'd8320;
  localparam logic [15:0] FocalYRst  = 16'd8320;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CfgDepthScale = 3'd0,
    CfgCenterX    = 3'd1,
    CfgCenterY    = 3'd2,
    CfgFocalX     = 3'd3,
    CfgFocalY     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
    logic [15:0] depth_raw;
    logic [7:0]  in_blue;
    logic [7:0]  in_green;
    logic [7:0]  in_red;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [30:0]        point_z;
    logic [7:0]         out_blue;
    logic [7:0]         out_green;
    logic [7:0]         out_red;
  } point_t;

  // Data that rides beside the dividers.
  typedef struct packed {
    logic       neg_x;
    logic       neg_y;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } side_t;

endpackage

>>> rtl/dpbp_divider.sv
// Pipelined restoring divider, one quotient bit per stage, for dpbp.
// Depends on dpbp_pkg. The divisor must be held steady while items are in flight.
module dpbp_divider (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [dpbp_pkg::NumW-1:0] num_i,
  input  logic [dpbp_pkg::DenW-1:0] den_i,
  output logic [dpbp_pkg::QuoW-1:0] quo_o,
  output logic                      sat_o
);
  import dpbp_pkg::*;

  logic [NumW-1:0] rem_q [0:QuoW];
  logic [QuoW-1:0] quo_q [0:QuoW];
  logic            sat_q [0:QuoW];

  // Entry stage: flag quotients that do not fit in QuoW bits.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      quo_q[0] <= '0;
      sat_q[0] <= {{(2*DenW-NumW){1'b0}}, num_i} >= {den_i, {QuoW{1'b0}}};
    end
  end

  // One subtract and compare per stage, most significant quotient bit first.
  for (genvar k = 1; k <= QuoW; k++) begin : g_stage
    localparam int unsigned Bit = QuoW - k;
    logic [NumW+DenW-1:0] den_sh;
    logic [NumW+DenW-1:0] rem_ext;
    logic                 fits;
    assign den_sh  = {{NumW{1'b0}}, den_i} << Bit;
    assign rem_ext = {{DenW{1'b0}}, rem_q[k-1]};
    assign fits    = rem_ext >= den_sh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= fits ? rem_q[k-1] - den_sh[NumW-1:0] : rem_q[k-1];
        quo_q[k] <= quo_q[k-1] | (QuoW'(fits) << Bit);
        sat_q[k] <= sat_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[QuoW];
  assign sat_o = sat_q[QuoW];

endmodule

>>> rtl/depth_pixel_back_projection.sv
// Top level: pinhole back-projection of depth pixels to colored Q16.16 points.
// Depends on dpbp_pkg and dpbp_divider.
//
//  channel | direction | signals                                  | transaction
//  pixel   | in        | in_valid_i, in_stall_o, in_pix_i         | valid & !stall
//  point   | out       | out_valid_o, out_stall_i, out_pt_o       | valid & !stall
//  config  | in        | cfg_we_i, cfg_idx_i, cfg_wdata_i         | cfg_we_i
//
// One pixel is accepted per cycle while the pipeline is not held. Its point
// is presented from the output register, after three input stages and the three
// 33-stage dividers: an entry stage, then one quotient bit per stage, the three
// dividers running side by side.
// Black pixels and pixels with depth outside 300..9000 leave no point.
// The whole pipeline holds while the output register is full and stalled.
// Reset empties the pipeline and restores the register defaults.
module depth_pixel_back_projection (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dpbp_pkg::pixel_t  in_pix_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dpbp_pkg::point_t  out_pt_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i
);
  import dpbp_pkg::*;

  logic adv;
  logic out_valid_q;
  point_t out_pt_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Configuration registers.
  logic [15:0] scale_q, cx_q, cy_q, fx_q, fy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleRst;
      cx_q    <= CenterXRst;
      cy_q    <= CenterYRst;
      fx_q    <= FocalXRst;
      fy_q    <= FocalYRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDepthScale: scale_q <= cfg_wdata_i;
        CfgCenterX:    cx_q    <= cfg_wdata_i;
        CfgCenterY:    cy_q    <= cfg_wdata_i;
        CfgFocalX:     fx_q    <= cfg_wdata_i;
        CfgFocalY:     fy_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Divisors, a zero register counting as one.
  logic [15:0] scale_nz, fx_nz, fy_nz;
  logic [DenW-1:0] den_x_q, den_y_q, den_z_q;
  assign scale_nz = (scale_q == '0) ? 16'd1 : scale_q;
  assign fx_nz    = (fx_q == '0) ? 16'd1 : fx_q;
  assign fy_nz    = (fy_q == '0) ? 16'd1 : fy_q;
  always_ff @(posedge clk_i) begin
    den_x_q <= scale_nz * fx_nz;
    den_y_q <= scale_nz * fy_nz;
    den_z_q <= DenW'(scale_nz);
  end

  // Stage 1: register the pixel, keeping only those that make a point.
  logic   keep;
  logic   v1_q;
  pixel_t p1_q;
  assign keep = in_valid_i
             && ((in_pix_i.in_blue | in_pix_i.in_green | in_pix_i.in_red) != '0)
             && (in_pix_i.depth_raw >= DepthMin) && (in_pix_i.depth_raw <= DepthMax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= keep;
  end
  always_ff @(posedge clk_i) begin
    if (adv) p1_q <= in_pix_i;
  end

  // Stage 2: distance from the principal point, as sign and magnitude.
  logic [16:0] dx, dy;
  logic        v2_q;
  logic [15:0] mag_x_q, mag_y_q, d2_q;
  side_t       s2_q;
  assign dx = {1'b0, p1_q.pixel_col, 4'b0} - {1'b0, cx_q};
  assign dy = {1'b0, p1_q.pixel_row, 4'b0} - {1'b0, cy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_x_q    <= dx[16] ? 16'(-dx) : dx[15:0];
      mag_y_q    <= dy[16] ? 16'(-dy) : dy[15:0];
      d2_q       <= p1_q.depth_raw;
      s2_q.neg_x <= dx[16];
      s2_q.neg_y <= dy[16];
      s2_q.blue  <= p1_q.in_blue;
      s2_q.green <= p1_q.in_green;
      s2_q.red   <= p1_q.in_red;
    end
  end

  // Stage 3: numerators in units of 2^-16.
  logic [31:0]     prod_x, prod_y;
  logic            v3_q;
  logic [NumW-1:0] num_x_q, num_y_q, num_z_q;
  side_t           s3_q;
  assign prod_x = mag_x_q * d2_q;
  assign prod_y = mag_y_q * d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_x_q <= {prod_x, 16'b0};
      num_y_q <= {prod_y, 16'b0};
      num_z_q <= {16'b0, d2_q, 16'b0};
      s3_q    <= s2_q;
    end
  end

  // Three dividers run side by side.
  logic [QuoW-1:0] q_x, q_y, q_z;
  logic            sat_x, sat_y, sat_z;

  dpbp_divider u_div_x (
    .clk_i (clk_i), .en_i (adv), .num_i (num_x_q), .den_i (den_x_q),
    .quo_o (q_x),   .sat_o (sat_x)
  );
  dpbp_divider u_div_y (
    .clk_i (clk_i), .en_i (adv), .num_i (num_y_q), .den_i (den_y_q),
    .quo_o (q_y),   .sat_o (sat_y)
  );
  dpbp_divider u_div_z (
    .clk_i (clk_i), .en_i (adv), .num_i (num_z_q), .den_i (den_z_q),
    .quo_o (q_z),   .sat_o (sat_z)
  );

  // Valid bits and sideband follow the divider stages.
  logic  vd_q [0:DivLat-1];
  side_t sd_q [0:DivLat-1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivLat; i++) vd_q[i] <= 1'b0;
    end else if (adv) begin
      vd_q[0] <= v3_q;
      for (int i = 1; i < DivLat; i++) vd_q[i] <= vd_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0] <= s3_q;
      for (int i = 1; i < DivLat; i++) sd_q[i] <= sd_q[i-1];
    end
  end

  // Saturation and sign, then the output register.
  logic [31:0] x_val, y_val;
  side_t       st;
  assign st = sd_q[DivLat-1];

  always_comb begin
    if (st.neg_x) x_val = (sat_x || q_x > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q_x);
    else          x_val = (sat_x || q_x > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_x;
    if (st.neg_y) y_val = (sat_y || q_y > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q_y);
    else          y_val = (sat_y || q_y > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= vd_q[DivLat-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pt_q.point_x   <= x_val;
      out_pt_q.point_y   <= y_val;
      out_pt_q.point_z   <= (sat_z || q_z[31]) ? 31'h7FFF_FFFF : q_z[30:0];
      out_pt_q.out_blue  <= st.blue;
      out_pt_q.out_green <= st.green;
      out_pt_q.out_red   <= st.red;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pt_o    = out_pt_q;

  // A valid pixel in the first stage is never black.
  a_no_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> ((p1_q.in_blue | p1_q.in_green | p1_q.in_red) != '0))
    else $error("black pixel entered the pipeline");

  // A point at the divider tail reaches the output on the next advance.
  a_tail_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vd_q[DivLat-1]) |=> out_valid_q)
    else $error("point lost between divider and output");

  // The pipeline holds only because of a full, stalled output.
  a_hold_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("pipeline held without a stalled output");

  // A held pipeline keeps its stage-3 valid bit.
  a_hold_v3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v3_q))
    else $error("stage 3 changed while held");

endmodule
